[hw/rtl/cartesian_to_polar_radar_defines.svh]
// assertion macros shared by the range/bearing/range-rate rtl
// needs clk_i and rst_ni in the module that uses them
`ifndef CARTESIAN_TO_POLAR_RADAR_DEFINES_SVH
`define CARTESIAN_TO_POLAR_RADAR_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define C2P_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("c2p assertion failed");
`define C2P_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("c2p forbidden condition seen");
`else
`define C2P_ASSERT(lbl, prop)
`define C2P_ASSERT_NEVER(lbl, cond)
`endif
`endif

[hw/rtl/c2p_pkg.sv]
// constants, types and the arctangent table of the cartesian-to-polar block
// no dependencies
`timescale 1ns / 1ps
package c2p_pkg;

  localparam int CORDIC_STEPS = 24;
  localparam int MAX_STEPS    = 40;
  localparam int N_STEPS      = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;
  localparam int GUARD        = 8;
  // cordic coordinate and angle widths
  localparam int XW           = 43;
  localparam int ZW           = 35;
  localparam int DIV_STEPS    = 32;
  localparam int FIFO_DEPTH   = 2;
  localparam int FIFO_AW      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W        = $clog2(FIFO_DEPTH + 1);

  localparam logic [31:0]          KINV_Q32    = 32'd2608131496;
  localparam logic signed [34:0]   PI_Q30      = 35'sd3373259426;
  localparam logic [31:0]          RANGE_MAX   = 32'd3037000500;
  localparam logic [20:0]          BEARING_MAX = 21'd205887;

  // classified item between front and back
  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 origin;
    logic signed [31:0]   px;
    logic signed [31:0]   py;
    logic signed [31:0]   vx;
    logic signed [31:0]   vy;
  } c2p_item_t;

  // arctangent of 2^-i in q30 radians
  function automatic logic [29:0] atan_entry(input int unsigned i);
    logic [29:0] r;
    r = '0;
    case (i)
      0:  r = 30'd843314856;
      1:  r = 30'd497837829;
      2:  r = 30'd263043836;
      3:  r = 30'd133525158;
      4:  r = 30'd67021686;
      5:  r = 30'd33543515;
      6:  r = 30'd16775850;
      7:  r = 30'd8388437;
      8:  r = 30'd4194282;
      9:  r = 30'd2097149;
      10: r = 30'd1048575;
      default: begin
        if (i <= 29) r = (30'd1 << 5'(30 - i)) - 30'd1;
        else r = '0;
      end
    endcase
    return r;
  endfunction

endpackage

[hw/rtl/c2p_if.sv]
// valid/ready channel interfaces for state items and polar results
// depends on nothing
`timescale 1ns / 1ps
interface c2p_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  modport source (output valid, pos_x, pos_y, vel_x, vel_y, input ready);
  modport sink (input valid, pos_x, pos_y, vel_x, vel_y, output ready);
endinterface

interface c2p_out_if;
  logic               valid;
  logic               ready;
  logic [31:0]        range;
  logic signed [18:0] bearing;
  logic signed [32:0] range_rate;
  logic               zero_range;
  modport source (output valid, range, bearing, range_rate, zero_range, input ready);
  modport sink (input valid, range, bearing, range_rate, zero_range, output ready);
endinterface

[hw/rtl/c2p_front.sv]
// front end: takes state items, folds the left half-plane, registers the item
// depends on c2p_pkg and c2p_if
`timescale 1ns / 1ps
module c2p_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  c2p_in_if.sink             in_i,
  output c2p_pkg::c2p_item_t item_o,
  output logic               item_valid_o,
  input  logic               item_ready_i
);
  localparam int XW = c2p_pkg::XW;
  localparam int ZW = c2p_pkg::ZW;

  logic                 vld_q;
  c2p_pkg::c2p_item_t   item_q, item_d;
  logic signed [XW-1:0] xe, ye;
  logic                 left;

  assign in_i.ready = !vld_q || item_ready_i;

  // guard shift and left half-plane fold
  always_comb begin
    xe   = XW'(in_i.pos_x) <<< c2p_pkg::GUARD;
    ye   = XW'(in_i.pos_y) <<< c2p_pkg::GUARD;
    left = in_i.pos_x < 0;
    item_d.x      = left ? -xe : xe;
    item_d.y      = left ? -ye : ye;
    item_d.z      = !left ? '0 :
                    (in_i.pos_y >= 0) ? c2p_pkg::PI_Q30 : ZW'(-c2p_pkg::PI_Q30);
    item_d.origin = (in_i.pos_x == 0) && (in_i.pos_y == 0);
    item_d.px     = in_i.pos_x;
    item_d.py     = in_i.pos_y;
    item_d.vx     = in_i.vel_x;
    item_d.vy     = in_i.vel_y;
  end

  // holding register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_i.ready) begin
      vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      item_q <= item_d;
    end
  end

  assign item_o       = item_q;
  assign item_valid_o = vld_q;
endmodule

[hw/rtl/c2p_fifo.sv]
// short queue of classified items between front and back
// depends on c2p_pkg and the assertion macros
`timescale 1ns / 1ps
`include "cartesian_to_polar_radar_defines.svh"
module c2p_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  c2p_pkg::c2p_item_t wr_item_i,
  input  logic               wr_valid_i,
  output logic               wr_ready_o,
  output c2p_pkg::c2p_item_t rd_item_o,
  output logic               rd_valid_o,
  input  logic               rd_ready_i
);
  localparam int DEPTH = c2p_pkg::FIFO_DEPTH;
  localparam int AW    = c2p_pkg::FIFO_AW;
  localparam int CW    = c2p_pkg::CNT_W;

  c2p_pkg::c2p_item_t mem_q [DEPTH];
  logic [AW-1:0]      wp_q, rp_q;
  logic [CW-1:0]      cnt_q;
  logic               push, pop;

  assign wr_ready_o = cnt_q != CW'(DEPTH);
  assign rd_valid_o = cnt_q != '0;
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;
  assign rd_item_o  = mem_q[rp_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + AW'(1);
      if (pop)  rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + AW'(1);
      cnt_q <= cnt_q + CW'(push) - CW'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= wr_item_i;
    end
  end

  `C2P_ASSERT(cnt_bound_a, cnt_q <= CW'(DEPTH))
  `C2P_ASSERT(cnt_track_a, 1'b1 |=> cnt_q == $past(cnt_q) + CW'($past(push)) - CW'($past(pop)))
endmodule

[hw/rtl/c2p_back.sv]
// back end: cordic vectoring, gain fix, dot product, range-rate divider
// depends on c2p_pkg, c2p_if and the assertion macros
`timescale 1ns / 1ps
`include "cartesian_to_polar_radar_defines.svh"
module c2p_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  c2p_pkg::c2p_item_t item_i,
  input  logic               item_valid_i,
  output logic               item_ready_o,
  c2p_out_if.source          res_o
);
  localparam int N    = c2p_pkg::N_STEPS;
  localparam int XW   = c2p_pkg::XW;
  localparam int ZW   = c2p_pkg::ZW;
  localparam int DS   = c2p_pkg::DIV_STEPS;
  localparam int LAST = N + 3 + DS;

  logic en;
  logic vld_q [0:LAST];

  // cordic stages
  logic signed [XW-1:0] x_q [0:N];
  logic signed [XW-1:0] y_q [0:N];
  logic signed [ZW-1:0] z_q [0:N];
  logic                 org_q [0:N];
  logic signed [31:0]   px_q, py_q, vx_q, vy_q;

  // dot product path
  logic signed [63:0] p1, p2;
  logic signed [63:0] p1_q, p2_q;
  logic [63:0]        m1_q, m2_q;
  logic               n1_q, n2_q;
  logic [63:0]        nmag_q [3:N];
  logic               nneg_q [3:N];

  // gain and bearing stages
  logic [XW-2:0]      magx;
  logic [ZW-1:0]      zmag;
  logic [ZW-15:0]     bm;
  logic [41:0]        hk_q;
  logic [63:0]        lk_q;
  logic signed [18:0] g1_brg_q, g2_brg_q;
  logic               g1_org_q, g2_org_q;
  logic [63:0]        g1_nmag_q, g2_nmag_q;
  logic               g1_nneg_q, g2_nneg_q;
  logic [42:0]        tsum;
  logic [34:0]        rr;
  logic [31:0]        g2_rng_q;
  logic [63:0]        num;

  // divider stages
  logic [31:0]        rem_q  [0:DS];
  logic [31:0]        low_q  [0:DS];
  logic [31:0]        quo_q  [0:DS];
  logic [31:0]        rng_q  [0:DS];
  logic signed [18:0] brg_q  [0:DS];
  logic               zero_q [0:DS];
  logic               neg_q  [0:DS];
  logic               ovf_q  [0:DS];

  // output register
  logic               out_vld_q;
  logic [31:0]        out_rng_q;
  logic signed [18:0] out_brg_q;
  logic signed [32:0] out_rate_q;
  logic               out_zero_q;
  logic [31:0]        qsat;

  // whole pipeline moves unless the result register is held
  assign en           = !out_vld_q || res_o.ready;
  assign item_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= LAST; i++) vld_q[i] <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q[0] <= item_valid_i;
      for (int i = 1; i <= LAST; i++) vld_q[i] <= vld_q[i-1];
      out_vld_q <= vld_q[LAST];
    end
  end

  // entry stage
  always_ff @(posedge clk_i) begin
    if (en) begin
      x_q[0]   <= item_i.x;
      y_q[0]   <= item_i.y;
      z_q[0]   <= item_i.z;
      org_q[0] <= item_i.origin;
      px_q     <= item_i.px;
      py_q     <= item_i.py;
      vx_q     <= item_i.vx;
      vy_q     <= item_i.vy;
    end
  end

  // one micro-rotation per stage
  for (genvar s = 0; s < N; s++) begin : g_cordic
    localparam logic [ZW-1:0] ATN = ZW'(c2p_pkg::atan_entry(s));
    always_ff @(posedge clk_i) begin
      if (en) begin
        if (y_q[s] < 0) begin
          x_q[s+1] <= x_q[s] - (y_q[s] >>> s);
          y_q[s+1] <= y_q[s] + (x_q[s] >>> s);
          z_q[s+1] <= z_q[s] - ATN;
        end else begin
          x_q[s+1] <= x_q[s] + (y_q[s] >>> s);
          y_q[s+1] <= y_q[s] - (x_q[s] >>> s);
          z_q[s+1] <= z_q[s] + ATN;
        end
        org_q[s+1] <= org_q[s];
      end
    end
  end

  // dot product: multiply, magnitude, signed-magnitude sum
  assign p1 = px_q * vx_q;
  assign p2 = py_q * vy_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_q <= p1;
      p2_q <= p2;
      m1_q <= (p1_q < 0) ? 64'(-p1_q) : 64'(p1_q);
      m2_q <= (p2_q < 0) ? 64'(-p2_q) : 64'(p2_q);
      n1_q <= p1_q < 0;
      n2_q <= p2_q < 0;
      if (n1_q == n2_q) begin
        nmag_q[3] <= m1_q + m2_q;
        nneg_q[3] <= n1_q;
      end else if (m1_q >= m2_q) begin
        nmag_q[3] <= m1_q - m2_q;
        nneg_q[3] <= n1_q;
      end else begin
        nmag_q[3] <= m2_q - m1_q;
        nneg_q[3] <= n2_q;
      end
      for (int i = 4; i <= N; i++) begin
        nmag_q[i] <= nmag_q[i-1];
        nneg_q[i] <= nneg_q[i-1];
      end
    end
  end

  // gain products and bearing rounding
  always_comb begin
    magx = (x_q[N] < 0) ? (XW-1)'(-x_q[N]) : (XW-1)'(x_q[N]);
    zmag = (z_q[N] < 0) ? ZW'(-z_q[N]) : ZW'(z_q[N]);
    bm   = (ZW-14)'((zmag + ZW'(1 << 13)) >> 14);
    if (bm > c2p_pkg::BEARING_MAX) bm = c2p_pkg::BEARING_MAX;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hk_q      <= magx[XW-2:32] * c2p_pkg::KINV_Q32;
      lk_q      <= magx[31:0] * c2p_pkg::KINV_Q32;
      g1_brg_q  <= org_q[N] ? '0 : (z_q[N] < 0) ? -19'(bm) : 19'(bm);
      g1_org_q  <= org_q[N];
      g1_nmag_q <= nmag_q[N];
      g1_nneg_q <= nneg_q[N];
    end
  end

  // range: sum, drop guard bits, clamp
  always_comb begin
    tsum = 43'(hk_q) + 43'(lk_q[63:32]);
    rr   = 35'((tsum + 43'd128) >> c2p_pkg::GUARD);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      g2_rng_q  <= g1_org_q ? '0 :
                   (rr > 35'(c2p_pkg::RANGE_MAX)) ? c2p_pkg::RANGE_MAX : rr[31:0];
      g2_brg_q  <= g1_brg_q;
      g2_org_q  <= g1_org_q;
      g2_nmag_q <= g1_nmag_q;
      g2_nneg_q <= g1_nneg_q;
    end
  end

  // divider setup: rounding offset and overflow check
  assign num = g2_nmag_q + 64'(g2_rng_q >> 1);

  always_ff @(posedge clk_i) begin
    if (en) begin
      rem_q[0]  <= num[63:32];
      low_q[0]  <= num[31:0];
      quo_q[0]  <= '0;
      rng_q[0]  <= g2_rng_q;
      brg_q[0]  <= g2_brg_q;
      zero_q[0] <= g2_org_q || (g2_rng_q == '0);
      neg_q[0]  <= g2_nneg_q;
      ovf_q[0]  <= num[63:32] >= g2_rng_q;
    end
  end

  // restoring division, one quotient bit per stage
  for (genvar k = 0; k < DS; k++) begin : g_div
    logic [32:0] trial;
    logic        ge;
    assign trial = {rem_q[k], low_q[k][31]};
    assign ge    = trial >= {1'b0, rng_q[k]};
    always_ff @(posedge clk_i) begin
      if (en) begin
        rem_q[k+1]  <= ge ? 32'(trial - {1'b0, rng_q[k]}) : trial[31:0];
        low_q[k+1]  <= {low_q[k][30:0], 1'b0};
        quo_q[k+1]  <= {quo_q[k][30:0], ge};
        rng_q[k+1]  <= rng_q[k];
        brg_q[k+1]  <= brg_q[k];
        zero_q[k+1] <= zero_q[k];
        neg_q[k+1]  <= neg_q[k];
        ovf_q[k+1]  <= ovf_q[k];
      end
    end
  end

  // saturate quotient, apply sign
  assign qsat = (ovf_q[DS] || quo_q[DS] > c2p_pkg::RANGE_MAX) ?
                c2p_pkg::RANGE_MAX : quo_q[DS];

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_rng_q  <= rng_q[DS];
      out_brg_q  <= brg_q[DS];
      out_zero_q <= zero_q[DS];
      out_rate_q <= zero_q[DS] ? '0 : neg_q[DS] ? -33'(qsat) : 33'(qsat);
    end
  end

  assign res_o.valid      = out_vld_q;
  assign res_o.range      = out_rng_q;
  assign res_o.bearing    = out_brg_q;
  assign res_o.range_rate = out_rate_q;
  assign res_o.zero_range = out_zero_q;

  `C2P_ASSERT(zero_flag_a, out_vld_q |-> out_zero_q == (out_rng_q == '0))
  `C2P_ASSERT(zero_rate_a, out_vld_q && out_zero_q |-> out_rate_q == '0)
endmodule

[hw/rtl/cartesian_to_polar_radar.sv]
// top level: cartesian state to range, bearing and range rate
// depends on c2p_pkg, c2p_if, c2p_front, c2p_fifo, c2p_back
//
// usage:
//   in_i carries one state item (pos_x, pos_y, vel_x, vel_y, signed q15.16)
//   with valid/ready; an item is taken when both are high at a clock edge.
//   res_o carries one result per item (range, bearing, range_rate,
//   zero_range) with valid/ready, in the order the items came in.
//   throughput is one item per cycle while res_o.ready stays high.
//   from acceptance to res_o.valid an item passes the front register,
//   the queue, the entry stage, the cordic stages, three gain and
//   setup stages, 32 divider stages and the result register.
//   when res_o.ready is low while a result is waiting, the whole back
//   pipeline holds; the front and the two-entry queue keep taking items
//   until they fill.
//   reset (rst_ni low, asynchronous) empties the queue and all stages; no
//   clearing pass is needed and no state carries over between items.
//   an item at the origin, or with a range that rounds to zero, gives
//   range_rate 0 with zero_range set.
`timescale 1ns / 1ps
module cartesian_to_polar_radar (
  input  logic      clk_i,
  input  logic      rst_ni,
  c2p_in_if.sink    in_i,
  c2p_out_if.source res_o
);
  c2p_pkg::c2p_item_t fr_item, q_item;
  logic               fr_valid, fr_ready, q_valid, q_ready;

  c2p_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .item_o       (fr_item),
    .item_valid_o (fr_valid),
    .item_ready_i (fr_ready)
  );

  c2p_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_item_i  (fr_item),
    .wr_valid_i (fr_valid),
    .wr_ready_o (fr_ready),
    .rd_item_o  (q_item),
    .rd_valid_o (q_valid),
    .rd_ready_i (q_ready)
  );

  c2p_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (q_item),
    .item_valid_i (q_valid),
    .item_ready_o (q_ready),
    .res_o        (res_o)
  );
endmodule
